FILE: rtl/core/fpa_pkg.sv
// Shared types, constants and rescale helpers for the fixed-point ALU.
package fpa_pkg;

	localparam int DW         = 32;
	localparam int DIV_STAGES = DW;
	localparam int LATENCY    = DIV_STAGES + 4;

	typedef enum logic [1:0] {
		CMD_ROUND     = 2'd0,
		CMD_MUL_CONV  = 2'd1,
		CMD_MUL_ROUND = 2'd2,
		CMD_DIV       = 2'd3
	} cmd_t;

	typedef struct packed {
		logic          valid;
		cmd_t          cmd;
		logic          dz;
		logic          neg;
		logic [DW-1:0] res;
		logic [DW-1:0] rem;
		logic [DW-1:0] dvd;
		logic [DW-1:0] dvs;
	} div_t;

	function automatic logic [DW-1:0] sra(input logic [DW-1:0] v, input logic [6:0] s);
		logic [DW-1:0] r;
		if (s >= 7'(DW)) begin
			r = {DW{v[DW-1]}};
		end else begin
			r = DW'($signed(v) >>> s);
		end
		return r;
	endfunction

	function automatic logic [DW-1:0] rescale(input logic [DW-1:0] v,
			input logic [6:0] fi, input logic [6:0] fo);
		logic [DW-1:0] t;
		logic [6:0]    d;
		if (fi > fo) begin
			d = 7'(fi - fo - 7'd1);
			t = sra(v, d) + DW'(1);
			t = sra(t, 7'd1);
		end else begin
			d = 7'(fo - fi);
			t = (d >= 7'(DW)) ? '0 : DW'(v << d);
		end
		return t;
	endfunction

endpackage

FILE: rtl/core/fpa_front.sv
// Front pipeline: operand rescale, multiply, product rescale and divide setup.
module fpa_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      command,
	input  logic [31:0]     operand_a,
	input  logic [31:0]     operand_b,
	input  logic [4:0]      format_a,
	input  logic [4:0]      format_b,
	input  logic [4:0]      format_out,
	output fpa_pkg::div_t   out
);
	import fpa_pkg::*;

	cmd_t          cmd_in;
	logic [6:0]    fa, fb, fo, tgt;
	logic          valid_s1, valid_s2;
	cmd_t          cmd_s1, cmd_s2;
	logic [DW-1:0] xa_s1, yb_s1;
	logic [6:0]    fi_s1, fo_s1, fi_s2, fo_s2;
	logic [DW-1:0] res_s2;
	logic          dz_s2, neg_s2;
	logic [DW-1:0] dvd_s2, dvs_s2;
	logic [DW-1:0] prod;

	assign cmd_in = cmd_t'(command);
	assign fa  = {2'b0, format_a};
	assign fb  = {2'b0, format_b};
	assign fo  = {2'b0, format_out};
	assign tgt = (cmd_in == CMD_DIV) ? 7'(fb + fo) : fo;

	// stage 1: bring operands to their working formats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd_in;
		xa_s1  <= (cmd_in == CMD_MUL_ROUND) ? operand_a : rescale(operand_a, fa, tgt);
		yb_s1  <= (cmd_in == CMD_MUL_CONV) ? rescale(operand_b, fb, fo) : operand_b;
		fi_s1  <= (cmd_in == CMD_MUL_CONV) ? 7'(fo + fo) : 7'(fa + fb);
		fo_s1  <= fo;
	end

	// stage 2: multiply, divide magnitudes
	assign prod = DW'(xa_s1 * yb_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s2 <= cmd_s1;
		res_s2 <= (cmd_s1 == CMD_MUL_CONV || cmd_s1 == CMD_MUL_ROUND) ? prod : xa_s1;
		fi_s2  <= fi_s1;
		fo_s2  <= fo_s1;
		dz_s2  <= (cmd_s1 == CMD_DIV) && (yb_s1 == '0);
		neg_s2 <= xa_s1[DW-1] ^ yb_s1[DW-1];
		dvd_s2 <= xa_s1[DW-1] ? DW'(-xa_s1) : xa_s1;
		dvs_s2 <= yb_s1[DW-1] ? DW'(-yb_s1) : yb_s1;
	end

	// stage 3: round the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out <= '0;
		end else begin
			out.valid <= valid_s2;
			out.cmd   <= cmd_s2;
			out.dz    <= dz_s2;
			out.neg   <= neg_s2;
			out.res   <= (cmd_s2 == CMD_MUL_CONV || cmd_s2 == CMD_MUL_ROUND)
			             ? rescale(res_s2, fi_s2, fo_s2) : res_s2;
			out.rem   <= '0;
			out.dvd   <= dvd_s2;
			out.dvs   <= dvs_s2;
		end
	end
endmodule

FILE: rtl/core/fpa_div.sv
// Pipelined restoring divider, one quotient bit per stage, other results ride along.
module fpa_div (
	input  logic          clk,
	input  logic          arst_n,
	input  fpa_pkg::div_t in,
	output fpa_pkg::div_t out
);
	import fpa_pkg::*;

	div_t st_q [DIV_STAGES];

	function automatic div_t step(input div_t s);
		div_t        n;
		logic [DW:0] r;
		logic [DW:0] t;
		n = s;
		r = {s.rem, s.dvd[DW-1]};
		t = r - {1'b0, s.dvs};
		n.dvd = {s.dvd[DW-2:0], ~t[DW]};
		n.rem = t[DW] ? r[DW-1:0] : t[DW-1:0];
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) st_q[i] <= '0;
		end else begin
			st_q[0] <= step(in);
			for (int i = 1; i < DIV_STAGES; i++) st_q[i] <= step(st_q[i-1]);
		end
	end

	assign out = st_q[DIV_STAGES-1];
endmodule

FILE: rtl/core/fixed_point_alu.sv
// Top level of the fixed-point ALU: front pipeline, divider and output register.
// Path from start to done: 3 front stages, 32 divider stages and the output register.
// Throughput: one beat per cycle for every command; busy stays low.
// The divider pipeline, one quotient bit per stage, sets the latency.
// The receiver cannot stall: done pulses for one cycle per beat.
// Reset (arst_n low) clears all valid bits; items in flight are dropped.
module fixed_point_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	input  logic [4:0]  format_a,
	input  logic [4:0]  format_b,
	input  logic [4:0]  format_out,
	output logic        done,
	output logic [31:0] result,
	output logic        divide_by_zero
);
	import fpa_pkg::*;

	div_t f2d, d2o;

	assign busy = 1'b0;

	fpa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.command    (command),
		.operand_a  (operand_a),
		.operand_b  (operand_b),
		.format_a   (format_a),
		.format_b   (format_b),
		.format_out (format_out),
		.out        (f2d)
	);

	fpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (f2d),
		.out    (d2o)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= d2o.valid;
		end
	end

	always_ff @(posedge clk) begin
		divide_by_zero <= d2o.dz;
		if (d2o.dz) begin
			result <= '0;
		end else if (d2o.cmd == CMD_DIV) begin
			result <= d2o.neg ? DW'(-d2o.dvd) : d2o.dvd;
		end else begin
			result <= d2o.res;
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LATENCY done) else $error("lost beat");
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_by_zero |-> result == '0) else $error("dz result nonzero");
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##LATENCY !done) else $error("invented beat");
endmodule

FILE: dv/tb_fixed_point_alu.sv
// Testbench for fixed_point_alu: random and directed beats checked against a predictor.
`timescale 1ns / 1ps

class alu_scoreboard;
	logic [31:0] exp_result[$];
	logic        exp_dz[$];
	int          errors;

	function automatic logic [31:0] shr_a(logic [31:0] v, int s);
		if (s >= 32) begin
			return {32{v[31]}};
		end
		return $signed(v) >>> s;
	endfunction

	function automatic logic [31:0] rescale_val(logic [31:0] v, int fi, int fo);
		logic [31:0] t;
		if (fi > fo) begin
			t = shr_a(v, fi - fo - 1) + 32'd1;
			return shr_a(t, 1);
		end
		if (fo - fi >= 32) begin
			return '0;
		end
		return v << (fo - fi);
	endfunction

	function void note_input(logic [1:0] cmd, logic [31:0] a, logic [31:0] b,
			int fa, int fb, int fo);
		logic [31:0] r, x, y, p, n, ma, mb, q;
		logic        dz;
		dz = 1'b0;
		case (fpa_pkg::cmd_t'(cmd))
			fpa_pkg::CMD_ROUND: begin
				r = rescale_val(a, fa, fo);
			end
			fpa_pkg::CMD_MUL_CONV: begin
				x = rescale_val(a, fa, fo);
				y = rescale_val(b, fb, fo);
				p = x * y;
				r = rescale_val(p, 2 * fo, fo);
			end
			fpa_pkg::CMD_MUL_ROUND: begin
				p = a * b;
				r = rescale_val(p, fa + fb, fo);
			end
			default: begin
				if (b == 0) begin
					dz = 1'b1;
					r = '0;
				end else begin
					n = rescale_val(a, fa, fb + fo);
					ma = n[31] ? -n : n;
					mb = b[31] ? -b : b;
					q = ma / mb;
					r = (n[31] != b[31]) ? -q : q;
				end
			end
		endcase
		exp_result.push_back(r);
		exp_dz.push_back(dz);
	endfunction

	task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		errors++;
	endtask

	task check_result(logic [31:0] r, logic dz);
		logic [31:0] er;
		logic        ed;
		if (exp_result.size() == 0) begin
			report_mismatch("unexpected beat", r, 0);
			return;
		end
		er = exp_result.pop_front();
		ed = exp_dz.pop_front();
		if (r !== er) report_mismatch("result", r, er);
		if (dz !== ed) report_mismatch("divide_by_zero", dz, ed);
	endtask
endclass

module tb_fixed_point_alu;
	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [1:0]  command = 0;
	logic [31:0] operand_a = 0;
	logic [31:0] operand_b = 0;
	logic [4:0]  format_a = 0;
	logic [4:0]  format_b = 0;
	logic [4:0]  format_out = 0;
	logic        done;
	logic [31:0] result;
	logic        divide_by_zero;
	int          cycles = 0;
	alu_scoreboard sb = new();

	fixed_point_alu dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("tb_fixed_point_alu failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result, divide_by_zero);
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return $urandom_range(0, 3);
			4: return -$urandom_range(1, 4);
			5: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task send_beat(logic [1:0] c, logic [31:0] a, logic [31:0] b,
			logic [4:0] fa, logic [4:0] fb, logic [4:0] fo, bit hold);
		start <= 1'b1;
		command <= c;
		operand_a <= a;
		operand_b <= b;
		format_a <= fa;
		format_b <= fb;
		format_out <= fo;
		do @(posedge clk); while (busy);
		sb.note_input(c, a, b, fa, fb, fo);
		if (!hold) start <= 1'b0;
	endtask

	task idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 2);
		repeat (n) @(posedge clk);
	endtask

	initial begin
		logic [31:0] a, b;
		int gap;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_beat(fpa_pkg::CMD_ROUND, 32'h7fff_ffff, 0, 31, 0, 0, 1);
		send_beat(fpa_pkg::CMD_ROUND, 32'h8000_0000, 0, 0, 0, 31, 1);
		send_beat(fpa_pkg::CMD_ROUND, 32'h0000_0003, 0, 1, 0, 0, 1);
		send_beat(fpa_pkg::CMD_ROUND, 32'hffff_fffd, 0, 1, 0, 0, 1);
		send_beat(fpa_pkg::CMD_ROUND, 32'h8000_0000, 0, 31, 31, 0, 1);
		send_beat(fpa_pkg::CMD_MUL_CONV, 32'h7fff_ffff, 32'h8000_0000, 31, 31, 31, 1);
		send_beat(fpa_pkg::CMD_MUL_CONV, 32'h0001_0000, 32'h0002_0000, 16, 16, 16, 1);
		send_beat(fpa_pkg::CMD_MUL_CONV, 32'hffff_ffff, 32'h0000_0005, 0, 0, 31, 1);
		send_beat(fpa_pkg::CMD_MUL_ROUND, 32'h7fff_ffff, 32'h7fff_ffff, 31, 31, 0, 1);
		send_beat(fpa_pkg::CMD_MUL_ROUND, 32'h8000_0000, 32'hffff_ffff, 0, 0, 31, 1);
		send_beat(fpa_pkg::CMD_MUL_ROUND, 32'h0000_0006, 32'hffff_fffd, 1, 1, 1, 1);
		send_beat(fpa_pkg::CMD_DIV, 32'h0000_0007, 32'h0000_0000, 0, 0, 0, 1);
		send_beat(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0, 1);
		send_beat(fpa_pkg::CMD_DIV, 32'hffff_fff9, 32'h0000_0002, 0, 0, 0, 1);
		send_beat(fpa_pkg::CMD_DIV, 32'h0000_0007, 32'hffff_fffe, 31, 31, 31, 1);
		send_beat(fpa_pkg::CMD_DIV, 32'h0001_0000, 32'h0003_0000, 16, 16, 16, 1);
		for (int i = 0; i < 1200; i++) begin
			a = rand_word();
			b = ($urandom_range(0, 19) == 0) ? 32'd0 : rand_word();
			gap = $urandom_range(0, 3);
			send_beat(2'($urandom_range(0, 3)), a, b, 5'($urandom_range(0, 31)),
				5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
				(gap == 0) && (i < 1199));
			if (gap != 0) idle_gap();
		end
		while (sb.exp_result.size() != 0) @(posedge clk);
		repeat (fpa_pkg::LATENCY + 10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_fixed_point_alu passed");
		end else begin
			$display("tb_fixed_point_alu failed");
		end
		$finish;
	end
endmodule

FILE: files.f
rtl/core/fpa_pkg.sv
rtl/core/fpa_front.sv
rtl/core/fpa_div.sv
rtl/core/fixed_point_alu.sv
dv/tb_fixed_point_alu.sv
